@@ sv/dstq_pkg.sv @@
`default_nettype none

package dstq_pkg;

    // operation codes
    typedef enum logic [1:0] {
        OP_INSERT     = 2'd0,
        OP_DISTRIBUTE = 2'd1,
        OP_COMPLETE   = 2'd2,
        OP_UNDO       = 2'd3
    } op_t;

    // status codes
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_MAIN_FULL     = 3'd1;
    localparam logic [2:0] ST_CLASS_EMPTY   = 3'd2;
    localparam logic [2:0] ST_CLASS_FULL    = 3'd3;
    localparam logic [2:0] ST_HISTORY_FULL  = 3'd4;
    localparam logic [2:0] ST_HISTORY_EMPTY = 3'd5;

    // fifo slots
    localparam logic [1:0] SLOT_PRIORITY = 2'd0;
    localparam logic [1:0] SLOT_MEDIUM   = 2'd1;
    localparam logic [1:0] SLOT_EASY     = 2'd2;

    localparam logic [1:0] CAT_PRIORITY = 2'd1;
    localparam logic [1:0] CAT_MEDIUM   = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] task_id;
        logic [15:0] due_date;
        logic [1:0]  category;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] moved_id;
        logic [15:0] moved_date;
        logic [1:0]  moved_category;
        logic [6:0]  main_count;
        logic [6:0]  history_count;
    } rsp_t;

    // one stored task
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] date;
        logic [1:0]  cat;
    } task_t;

    // map a category code to its fifo slot
    function automatic logic [1:0] slot_of(input logic [1:0] cat);
        logic [1:0] s;
        s = SLOT_EASY;
        if (cat == CAT_PRIORITY) s = SLOT_PRIORITY;
        else if (cat == CAT_MEDIUM) s = SLOT_MEDIUM;
        return s;
    endfunction

endpackage

`default_nettype wire

@@ sv/date_sorted_task_queue_with_history.sv @@
// Task engine: one response per request. Insert keeps the main table sorted by
// date, shifting entries up one at a time from the top: each entry is read, then
// compared and written. Distribute reads the main table twice (tally, then move),
// one entry at a time. Complete pops the head of a category fifo onto the history
// stack; undo pops the history stack; each reads its memory, then answers.
// Requests refused at acceptance answer straight from the idle state. The main
// table memory has a single read port with a registered read, so each entry
// takes a read state and a second state. One request is in work at a time; a new
// request is taken in the cycle after the previous response has been taken. The
// memories need no clearing after reset.
`default_nettype none

module date_sorted_task_queue_with_history #(
    parameter int MAIN_DEPTH    = 64,
    parameter int CLASS_DEPTH   = 64,
    parameter int HISTORY_DEPTH = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire dstq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output dstq_pkg::rsp_t     rsp
);

    localparam int MW  = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
    localparam int MCW = $clog2(MAIN_DEPTH + 1);
    localparam int CPW = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int CCW = $clog2(CLASS_DEPTH + 1);
    localparam int CAW = $clog2(3 * CLASS_DEPTH);
    localparam int HW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW  = ((MCW > CCW) ? MCW : CCW) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CMP, S_CNT_RD, S_CNT_ACC, S_CHK,
        S_MOV_RD, S_MOV_WR, S_CMP_RD, S_CMP_WR, S_UNDO_RD, S_UNDO_WR
    } state_t;

    state_t          state_reg;
    dstq_pkg::req_t  req_reg;
    dstq_pkg::rsp_t  rsp_reg;
    logic            rsp_valid_reg;
    logic [MCW-1:0]  idx_reg;
    logic [MCW-1:0]  main_cnt_reg;
    logic [HCW-1:0]  htop_reg;
    logic [MCW-1:0]  need_reg [3];
    logic [CPW-1:0]  head_reg [3];
    logic [CCW-1:0]  ccnt_reg [3];
    logic [1:0]      slot_reg;

    // memories
    dstq_pkg::task_t sorted_mem [MAIN_DEPTH];
    logic [31:0]     class_mem  [3 * CLASS_DEPTH];
    dstq_pkg::task_t hist_mem   [HISTORY_DEPTH];
    dstq_pkg::task_t sorted_rd_reg;
    logic [31:0]     class_rd_reg;
    dstq_pkg::task_t hist_rd_reg;

    logic            sorted_we;
    logic [MW-1:0]   sorted_waddr;
    dstq_pkg::task_t sorted_wdata;
    logic [MW-1:0]   sorted_raddr;
    logic            class_we;
    logic [CAW-1:0]  class_waddr;
    logic [CAW-1:0]  class_raddr;
    logic            hist_we;
    logic [HW-1:0]   hist_raddr;
    dstq_pkg::task_t new_task;
    logic [1:0]      mov_slot;
    logic [CCW:0]    tail_sum;
    logic [CPW-1:0]  tail_ptr;
    logic [CCW:0]    head_sum;
    logic [CPW-1:0]  head_next;
    logic            overflow;
    logic [2:0]      idle_status;
    logic            idle_done;

    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign new_task = '{id: req_reg.task_id, date: req_reg.due_date, cat: req_reg.category};
    assign mov_slot = dstq_pkg::slot_of(sorted_rd_reg.cat);

    // status of a new request that ends at once
    always_comb
    begin
        idle_status = dstq_pkg::ST_OK;
        idle_done   = 1'b0;
        case (dstq_pkg::op_t'(req.operation))
            dstq_pkg::OP_INSERT:
            begin
                if (main_cnt_reg >= MCW'(MAIN_DEPTH))
                begin
                    idle_status = dstq_pkg::ST_MAIN_FULL;
                    idle_done   = 1'b1;
                end
            end
            dstq_pkg::OP_DISTRIBUTE:
            begin
                idle_done = 1'b0;
            end
            dstq_pkg::OP_COMPLETE:
            begin
                if (ccnt_reg[dstq_pkg::slot_of(req.category)] == '0)
                begin
                    idle_status = dstq_pkg::ST_CLASS_EMPTY;
                    idle_done   = 1'b1;
                end
                else if (htop_reg >= HCW'(HISTORY_DEPTH))
                begin
                    idle_status = dstq_pkg::ST_HISTORY_FULL;
                    idle_done   = 1'b1;
                end
            end
            default:
            begin
                if (htop_reg == '0)
                begin
                    idle_status = dstq_pkg::ST_HISTORY_EMPTY;
                    idle_done   = 1'b1;
                end
            end
        endcase
    end

    // memory address and write control
    always_comb
    begin
        sorted_we    = 1'b0;
        sorted_waddr = MW'(idx_reg);
        sorted_wdata = new_task;
        sorted_raddr = MW'(idx_reg);
        if (state_reg == S_INS_RD)
        begin
            sorted_raddr = MW'(idx_reg - MCW'(1));
            sorted_we    = (idx_reg == '0);
        end
        else if (state_reg == S_INS_CMP)
        begin
            sorted_we = 1'b1;
            if (!(req_reg.due_date > sorted_rd_reg.date))
                sorted_wdata = sorted_rd_reg;
        end
        tail_sum = (CCW+1)'(head_reg[mov_slot]) + (CCW+1)'(ccnt_reg[mov_slot]);
        if (tail_sum >= (CCW+1)'(CLASS_DEPTH))
            tail_sum = tail_sum - (CCW+1)'(CLASS_DEPTH);
        tail_ptr    = CPW'(tail_sum);
        class_we    = (state_reg == S_MOV_WR);
        class_waddr = CAW'(CAW'(mov_slot) * CAW'(CLASS_DEPTH)) + CAW'(tail_ptr);
        class_raddr = CAW'(CAW'(slot_reg) * CAW'(CLASS_DEPTH)) + CAW'(head_reg[slot_reg]);
        head_sum    = (CCW+1)'(head_reg[slot_reg]) + (CCW+1)'(1);
        if (head_sum >= (CCW+1)'(CLASS_DEPTH))
            head_sum = '0;
        head_next   = CPW'(head_sum);
        hist_we     = (state_reg == S_CMP_WR);
        hist_raddr  = HW'(htop_reg - HCW'(1));
        overflow    = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (SW'(need_reg[k]) + SW'(ccnt_reg[k]) > SW'(CLASS_DEPTH))
                overflow = 1'b1;
        end
    end

    // main table memory
    always_ff @(posedge clk)
    begin
        if (sorted_we)
            sorted_mem[sorted_waddr] <= sorted_wdata;
        sorted_rd_reg <= sorted_mem[sorted_raddr];
    end

    // category fifo memory
    always_ff @(posedge clk)
    begin
        if (class_we)
            class_mem[class_waddr] <= {sorted_rd_reg.id, sorted_rd_reg.date};
        class_rd_reg <= class_mem[class_raddr];
    end

    // history stack memory
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[HW'(htop_reg)] <= '{id: class_rd_reg[31:16],
                                        date: class_rd_reg[15:0],
                                        cat: slot_reg + 2'd1};
        hist_rd_reg <= hist_mem[hist_raddr];
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            req_reg       <= '0;
            rsp_reg       <= '0;
            idx_reg       <= '0;
            main_cnt_reg  <= '0;
            htop_reg      <= '0;
            slot_reg      <= '0;
            for (int k = 0; k < 3; k++)
            begin
                need_reg[k] <= '0;
                head_reg[k] <= '0;
                ccnt_reg[k] <= '0;
            end
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && req_ready)
                    begin
                        req_reg  <= req;
                        slot_reg <= dstq_pkg::slot_of(req.category);
                        rsp_reg  <= '{status: idle_status, moved_id: '0,
                                     moved_date: '0, moved_category: '0,
                                     main_count: 7'(main_cnt_reg),
                                     history_count: 7'(htop_reg)};
                        if (idle_done)
                            rsp_valid_reg <= 1'b1;
                        else
                        begin
                            case (dstq_pkg::op_t'(req.operation))
                                dstq_pkg::OP_INSERT:
                                begin
                                    idx_reg   <= main_cnt_reg;
                                    state_reg <= S_INS_RD;
                                end
                                dstq_pkg::OP_DISTRIBUTE:
                                begin
                                    idx_reg <= '0;
                                    for (int k = 0; k < 3; k++)
                                        need_reg[k] <= '0;
                                    state_reg <= S_CNT_RD;
                                end
                                dstq_pkg::OP_COMPLETE:
                                    state_reg <= S_CMP_RD;
                                default:
                                    state_reg <= S_UNDO_RD;
                            endcase
                        end
                    end
                end
                S_INS_RD:
                begin
                    if (idx_reg == '0)
                    begin
                        main_cnt_reg       <= main_cnt_reg + MCW'(1);
                        rsp_reg.main_count <= 7'(main_cnt_reg + MCW'(1));
                        rsp_valid_reg      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                    else
                        state_reg <= S_INS_CMP;
                end
                S_INS_CMP:
                begin
                    if (req_reg.due_date > sorted_rd_reg.date)
                    begin
                        main_cnt_reg       <= main_cnt_reg + MCW'(1);
                        rsp_reg.main_count <= 7'(main_cnt_reg + MCW'(1));
                        rsp_valid_reg      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - MCW'(1);
                        state_reg <= S_INS_RD;
                    end
                end
                S_CNT_RD:
                begin
                    if (idx_reg == main_cnt_reg)
                        state_reg <= S_CHK;
                    else
                        state_reg <= S_CNT_ACC;
                end
                S_CNT_ACC:
                begin
                    need_reg[mov_slot] <= need_reg[mov_slot] + MCW'(1);
                    idx_reg            <= idx_reg + MCW'(1);
                    state_reg          <= S_CNT_RD;
                end
                S_CHK:
                begin
                    idx_reg <= '0;
                    if (overflow)
                    begin
                        rsp_reg.status <= dstq_pkg::ST_CLASS_FULL;
                        rsp_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                        state_reg <= S_MOV_RD;
                end
                S_MOV_RD:
                begin
                    if (idx_reg == main_cnt_reg)
                    begin
                        main_cnt_reg       <= '0;
                        rsp_reg.main_count <= '0;
                        rsp_valid_reg      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                    else
                        state_reg <= S_MOV_WR;
                end
                S_MOV_WR:
                begin
                    ccnt_reg[mov_slot] <= ccnt_reg[mov_slot] + CCW'(1);
                    idx_reg            <= idx_reg + MCW'(1);
                    state_reg          <= S_MOV_RD;
                end
                S_CMP_RD:
                    state_reg <= S_CMP_WR;
                S_CMP_WR:
                begin
                    head_reg[slot_reg] <= head_next;
                    ccnt_reg[slot_reg] <= ccnt_reg[slot_reg] - CCW'(1);
                    htop_reg           <= htop_reg + HCW'(1);
                    rsp_reg            <= '{status: dstq_pkg::ST_OK,
                                           moved_id: class_rd_reg[31:16],
                                           moved_date: class_rd_reg[15:0],
                                           moved_category: slot_reg + 2'd1,
                                           main_count: rsp_reg.main_count,
                                           history_count: 7'(htop_reg + HCW'(1))};
                    rsp_valid_reg      <= 1'b1;
                    state_reg          <= S_IDLE;
                end
                S_UNDO_RD:
                    state_reg <= S_UNDO_WR;
                S_UNDO_WR:
                begin
                    htop_reg      <= htop_reg - HCW'(1);
                    rsp_reg       <= '{status: dstq_pkg::ST_OK,
                                      moved_id: hist_rd_reg.id,
                                      moved_date: hist_rd_reg.date,
                                      moved_category: hist_rd_reg.cat,
                                      main_count: rsp_reg.main_count,
                                      history_count: 7'(htop_reg - HCW'(1))};
                    rsp_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    a_no_req_while_rsp_pending: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> !rsp_valid)
        else $error("request taken while a response is pending");

    a_main_bound: assert property (@(posedge clk) disable iff (!rst_n)
        main_cnt_reg <= MCW'(MAIN_DEPTH))
        else $error("main table count beyond depth");

    a_hist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        htop_reg <= HCW'(HISTORY_DEPTH))
        else $error("history count beyond depth");

    a_class_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ccnt_reg[0] <= CCW'(CLASS_DEPTH) && ccnt_reg[1] <= CCW'(CLASS_DEPTH)
        && ccnt_reg[2] <= CCW'(CLASS_DEPTH))
        else $error("category fifo count beyond depth");

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !req_ready)
        else $error("ready while a request is in work");

endmodule

`default_nettype wire
